// ===== design/crp_pkg.sv =====
`timescale 1ns / 1ps

package crp_pkg;

	// byte constants
	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_SP  = 8'd32;

	// register widths and reset values
	localparam int LEN_W = 24;
	localparam logic [LEN_W-1:0] DEFAULT_FIELD_LIMIT = 24'd131072;
	localparam logic [7:0]       DEFAULT_DELIM       = 8'd44;
	localparam logic [7:0]       DEFAULT_QUOTE       = 8'd34;
	localparam logic [8:0]       DEFAULT_ESCAPE      = 9'd256;

	// quoting modes with a meaning here
	localparam logic [2:0] QM_NONE    = 3'd3;
	localparam logic [2:0] QM_STRINGS = 3'd4;
	localparam logic [2:0] QM_NOTNULL = 3'd5;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_DELIM    = 3'd0,
		CFG_QUOTE    = 3'd1,
		CFG_ESCAPE   = 3'd2,
		CFG_DQUOTE   = 3'd3,
		CFG_SKIPSP   = 3'd4,
		CFG_QMODE    = 3'd5,
		CFG_STRICT   = 3'd6,
		CFG_LIMIT    = 3'd7
	} cfg_idx_t;

	// parser states, one-hot
	typedef enum logic [8:0] {
		PS_START_REC  = 9'b000000001,
		PS_START_FLD  = 9'b000000010,
		PS_ESCAPED    = 9'b000000100,
		PS_IN_FIELD   = 9'b000001000,
		PS_IN_QUOTED  = 9'b000010000,
		PS_ESC_IN_QT  = 9'b000100000,
		PS_QT_IN_QT   = 9'b001000000,
		PS_EAT_CRNL   = 9'b010000000,
		PS_AFTER_ESC  = 9'b100000000
	} ps_t;

	// status codes
	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_NUL       = 3'd1,
		STAT_TOO_LONG  = 3'd2,
		STAT_BAD_QUOTE = 3'd3,
		STAT_BAD_NL    = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0]       delimiter_char;
		logic [7:0]       quote_char;
		logic [8:0]       escape_char;
		logic             double_quote;
		logic             skip_initial_space;
		logic [2:0]       quoting_mode;
		logic             strict_mode;
		logic [LEN_W-1:0] field_limit;
	} cfg_t;

	typedef struct packed {
		ps_t              ps;
		logic             unquoted;
		logic [LEN_W-1:0] len;
	} parse_st_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_out;
		logic       field_end;
		logic       field_null;
		logic       record_end;
		status_t    status;
	} result_t;

endpackage

// ===== design/crp_cfg_regs.sv =====
`timescale 1ns / 1ps

module crp_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_addr,
	input  logic [crp_pkg::LEN_W-1:0]  cfg_wdata,
	output crp_pkg::cfg_t              cfg
);
	import crp_pkg::*;

	cfg_t cfg_q;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_char     <= DEFAULT_DELIM;
			cfg_q.quote_char         <= DEFAULT_QUOTE;
			cfg_q.escape_char        <= DEFAULT_ESCAPE;
			cfg_q.double_quote       <= 1'b1;
			cfg_q.skip_initial_space <= 1'b0;
			cfg_q.quoting_mode       <= 3'd0;
			cfg_q.strict_mode        <= 1'b0;
			cfg_q.field_limit        <= DEFAULT_FIELD_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_DELIM:  cfg_q.delimiter_char     <= cfg_wdata[7:0];
				CFG_QUOTE:  cfg_q.quote_char         <= cfg_wdata[7:0];
				CFG_ESCAPE: cfg_q.escape_char        <= cfg_wdata[8:0];
				CFG_DQUOTE: cfg_q.double_quote       <= cfg_wdata[0];
				CFG_SKIPSP: cfg_q.skip_initial_space <= cfg_wdata[0];
				CFG_QMODE:  cfg_q.quoting_mode       <= cfg_wdata[2:0];
				CFG_STRICT: cfg_q.strict_mode        <= cfg_wdata[0];
				CFG_LIMIT:  cfg_q.field_limit        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/crp_step.sv =====
`timescale 1ns / 1ps

module crp_step (
	input  crp_pkg::cfg_t      cfg,
	input  crp_pkg::parse_st_t cur,
	input  logic [7:0]         data_byte,
	input  logic               line_end,
	output crp_pkg::parse_st_t nxt,
	output crp_pkg::result_t   res
);
	import crp_pkg::*;

	logic is_nl, is_esc, is_qt, is_dl;

	// byte classes; the end-of-line marker matches none of them
	assign is_nl  = !line_end && (data_byte == CH_LF || data_byte == CH_CR);
	assign is_esc = !line_end && !cfg.escape_char[8] && (data_byte == cfg.escape_char[7:0]);
	assign is_qt  = !line_end && (cfg.quoting_mode != QM_NONE) && (data_byte == cfg.quote_char);
	assign is_dl  = !line_end && (data_byte == cfg.delimiter_char);

	always_comb begin
		parse_st_t st;
		status_t   stat;
		logic      add, save, eline, sf, inf;
		logic [7:0] ach;

		st    = cur;
		stat  = STAT_OK;
		add   = 1'b0;
		save  = 1'b0;
		eline = 1'b0;
		sf    = 1'b0;
		inf   = 1'b0;
		ach   = data_byte;
		res   = '0;

		if (!line_end && data_byte == CH_NUL) begin
			stat = STAT_NUL;
		end else begin
			// per-state dispatch
			unique case (cur.ps)
				PS_START_FLD: begin
					sf = 1'b1;
				end
				PS_ESCAPED: begin
					add = 1'b1;
					if (is_nl) begin
						st.ps = PS_AFTER_ESC;
					end else begin
						ach   = line_end ? CH_LF : data_byte;
						st.ps = PS_IN_FIELD;
					end
				end
				PS_AFTER_ESC: begin
					inf = !line_end;
				end
				PS_IN_FIELD: begin
					inf = 1'b1;
				end
				PS_IN_QUOTED: begin
					if (line_end) begin
						// line break inside quotes keeps the field open
					end else if (is_esc) begin
						st.ps = PS_ESC_IN_QT;
					end else if (is_qt) begin
						st.ps = cfg.double_quote ? PS_QT_IN_QT : PS_IN_FIELD;
					end else begin
						add = 1'b1;
					end
				end
				PS_ESC_IN_QT: begin
					add   = 1'b1;
					ach   = line_end ? CH_LF : data_byte;
					st.ps = PS_IN_QUOTED;
				end
				PS_QT_IN_QT: begin
					if (is_qt) begin
						add   = 1'b1;
						st.ps = PS_IN_QUOTED;
					end else if (is_dl) begin
						save  = 1'b1;
						st.ps = PS_START_FLD;
					end else if (line_end || is_nl) begin
						eline = 1'b1;
					end else if (!cfg.strict_mode) begin
						add   = 1'b1;
						st.ps = PS_IN_FIELD;
					end else begin
						stat = STAT_BAD_QUOTE;
					end
				end
				PS_EAT_CRNL: begin
					if (is_nl) begin
						// swallow
					end else if (line_end) begin
						st.ps = PS_START_REC;
					end else begin
						stat = STAT_BAD_NL;
					end
				end
				default: begin
					if (line_end) begin
						st.ps = PS_START_REC;
					end else if (is_nl) begin
						st.ps = PS_EAT_CRNL;
					end else begin
						st.ps = PS_START_FLD;
						sf    = 1'b1;
					end
				end
			endcase

			// start of field handling
			if (sf) begin
				st.unquoted = 1'b1;
				if (line_end || is_nl) begin
					eline = 1'b1;
				end else if (is_qt) begin
					st.unquoted = 1'b0;
					st.ps       = PS_IN_QUOTED;
				end else if (is_esc) begin
					st.ps = PS_ESCAPED;
				end else if (data_byte == CH_SP && cfg.skip_initial_space) begin
					// leading space dropped
				end else if (is_dl) begin
					save = 1'b1;
				end else begin
					add   = 1'b1;
					st.ps = PS_IN_FIELD;
				end
			end

			// inside an unquoted field
			if (inf) begin
				if (line_end || is_nl) begin
					eline = 1'b1;
				end else if (is_esc) begin
					st.ps = PS_ESCAPED;
				end else if (is_dl) begin
					save  = 1'b1;
					st.ps = PS_START_FLD;
				end else begin
					add = 1'b1;
				end
			end

			// end of line closes the field
			if (eline) begin
				save  = 1'b1;
				st.ps = line_end ? PS_START_REC : PS_EAT_CRNL;
			end

			// append with length check
			if (add) begin
				if (cur.len >= cfg.field_limit) begin
					stat = STAT_TOO_LONG;
				end else begin
					res.char_valid = 1'b1;
					res.char_out   = ach;
					st.len         = cur.len + LEN_W'(1);
				end
			end

			// field completion
			if (save) begin
				res.field_end  = 1'b1;
				res.field_null = st.unquoted && (cur.len == '0) &&
					(cfg.quoting_mode == QM_STRINGS || cfg.quoting_mode == QM_NOTNULL);
				st.len         = '0;
			end
		end

		// an error leaves state untouched and drops all marks
		if (stat != STAT_OK) begin
			nxt        = cur;
			res        = '0;
			res.status = stat;
		end else begin
			nxt            = st;
			res.status     = STAT_OK;
			res.record_end = line_end && (st.ps == PS_START_REC);
		end
	end

endmodule

// ===== design/csv_record_parser_unit.sv =====
`timescale 1ns / 1ps

// a result item goes from the input register through the parse step into the result
// register, which drives m_tdata/m_tuser/m_tlast; m_tready low can hold it in either stage
// throughput: 1 item per cycle while m_tready is high; the parse state register loops
// through the compare logic between the input register and the result register
// reset (arst_n low): parser at record start, field length zero, registers at
// their default values, both pipeline stages empty

module csv_record_parser_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_addr,
	input  logic [crp_pkg::LEN_W-1:0] cfg_wdata,
	// input items
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // [7:0] data_byte
	input  logic                      s_tlast,   // line_end
	// result items
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,   // [7:0] char_out
	output logic [5:0]                m_tuser,   // [0] char_valid, [1] field_end,
	                                             // [2] field_null, [5:3] status
	output logic                      m_tlast    // record_end
);
	import crp_pkg::*;

	cfg_t      cfg;
	parse_st_t state_q, state_nxt;
	result_t   step_res, res_s2;
	logic      valid_s1, valid_s2;
	logic [7:0] byte_s1;
	logic      eol_s1;
	logic      s2_free, adv;

	crp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	crp_step u_step (
		.cfg       (cfg),
		.cur       (state_q),
		.data_byte (byte_s1),
		.line_end  (eol_s1),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	// stage handshakes
	assign s2_free  = !valid_s2 || m_tready;
	assign adv      = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eol_s1  <= s_tlast;
		end
	end

	// parse state, updated as each item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.ps       <= PS_START_REC;
			state_q.unquoted <= 1'b0;
			state_q.len      <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= step_res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.char_out;
	assign m_tuser  = {res_s2.status, res_s2.field_null, res_s2.field_end, res_s2.char_valid};
	assign m_tlast  = res_s2.record_end;

	// checks
	a_err_no_marks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status != STAT_OK |->
			!res_s2.char_valid && !res_s2.field_end && !res_s2.record_end)
		else $error("error result carries marks");

	a_err_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv && step_res.status != STAT_OK |=> state_q == $past(state_q))
		else $error("error changed parse state");

	a_rec_end_start: assert property (@(posedge clk) disable iff (!arst_n)
		adv && step_res.record_end |=> state_q.ps == PS_START_REC)
		else $error("record end without return to record start");

	a_char_counts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && step_res.char_valid |=> state_q.len == $past(state_q.len) + LEN_W'(1))
		else $error("appended byte not counted");

	a_field_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && step_res.field_end |=> state_q.len == '0)
		else $error("field length not cleared at field end");

endmodule
